// ----- rtl/core/wals_pkg.sv -----
// Shared types, codes and constants of the weighted adjacency list store.
`timescale 1ns / 1ps
`default_nettype none

package wals_pkg;

	// Default sizes
	localparam int MAX_VERTICES_DEF = 128;
	localparam int MAX_DEGREE_DEF   = 16;

	// Fixed field widths
	localparam int REQ_W    = 3;
	localparam int VTX_W    = 7;
	localparam int WGT_W    = 16;
	localparam int STATUS_W = 2;
	localparam int SUM_W    = 21;

	// Saturation limits of the weight sum
	localparam int SUM_MAX_C = 1048575;
	localparam int SUM_MIN_C = -1048576;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADJ    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SUM    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ISO    = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

	// Register index, taken from paddr bit 2
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEN,
		ST_SCAN,
		ST_RSP
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;     // request word accepted
		logic clear;     // clearing pass over list lengths
		logic ins_wr;    // append edge and bump length
		logic scan;      // walk the list slots
		logic len_wr_k;  // write compacted length after removal
		logic rsp_load;  // load the result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             clear_done;
		logic             bad_range;
		logic             len_full;
		logic             scan_done;
		logic [REQ_W-1:0] req;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/wals_req_if.sv -----
// Request channel interface: valid/ready plus the request word.
`timescale 1ns / 1ps
`default_nettype none

interface wals_req_if;
	import wals_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [VTX_W-1:0]        src_vertex;
	logic [VTX_W-1:0]        dst_vertex;
	logic signed [WGT_W-1:0] weight;

	modport source (output valid, output req_type, output src_vertex, output dst_vertex,
		output weight, input ready);
	modport sink (input valid, input req_type, input src_vertex, input dst_vertex,
		input weight, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wals_rsp_if.sv -----
// Result channel interface: valid/ready plus the result word.
`timescale 1ns / 1ps
`default_nettype none

interface wals_rsp_if;
	import wals_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic                    found;
	logic signed [SUM_W-1:0] weight_sum;

	modport source (output valid, output status, output found, output weight_sum,
		input ready);
	modport sink (input valid, input status, input found, input weight_sum,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wals_ctrl.sv -----
// Controller state machine of the adjacency list store.
`timescale 1ns / 1ps
`default_nettype none

module wals_ctrl
	import wals_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  wire logic    rsp_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	ctl_state_t state_q, state_d;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on load, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_LEN;
			end
			ST_LEN: begin
				priority if (sts.bad_range) begin
					state_d = ST_RSP;
				end else if (sts.req == REQ_ADJ || sts.req == REQ_REMOVE
						|| sts.req == REQ_SUM) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RSP;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_RSP;
			end
			ST_RSP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.start = req_valid;
			end
			ST_LEN: begin
				cmd.ins_wr = !sts.bad_range && (sts.req == REQ_INSERT) && !sts.len_full;
			end
			ST_SCAN: begin
				cmd.scan     = 1'b1;
				cmd.len_wr_k = sts.scan_done && (sts.req == REQ_REMOVE);
			end
			ST_RSP: begin
				cmd.rsp_load = rsp_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/wals_dp.sv -----
// Datapath: list length memory, edge slot memory, scan counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module wals_dp
	import wals_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dp_cmd_t                 cmd,
	output dp_sts_t                      sts,
	input  wire logic [VTX_W-1:0]        vertex_count,
	input  wire logic [REQ_W-1:0]        in_req,
	input  wire logic [VTX_W-1:0]        in_src,
	input  wire logic [VTX_W-1:0]        in_dst,
	input  wire logic signed [WGT_W-1:0] in_weight,
	output logic [STATUS_W-1:0]          out_status,
	output logic                         out_found,
	output logic signed [SUM_W-1:0]      out_sum
);

	localparam int VW         = $clog2(MAX_VERTICES);
	localparam int LW         = $clog2(MAX_DEGREE + 1);
	localparam int EDGE_DEPTH = MAX_VERTICES * MAX_DEGREE;
	localparam int AW         = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
	localparam int EW         = VTX_W + WGT_W;
	localparam int ACC_W      = WGT_W + LW;
	localparam int CMP_W      = ((ACC_W > SUM_W) ? ACC_W : SUM_W) + 1;
	localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'(SUM_MAX_C);
	localparam logic signed [CMP_W-1:0] SAT_LO = CMP_W'(SUM_MIN_C);

	// Memories
	logic [LW-1:0] len_mem  [0:MAX_VERTICES-1];
	logic [EW-1:0] edge_mem [0:EDGE_DEPTH-1];

	// Request capture
	logic [REQ_W-1:0]        req_q;
	logic [VTX_W-1:0]        dst_q;
	logic signed [WGT_W-1:0] weight_q;
	logic [VW-1:0]           src_idx_q;
	logic [AW-1:0]           base_q;
	logic                    bad_range_q;

	// Scan state
	logic [LW-1:0]           len_rd_s1;
	logic [EW-1:0]           edge_rd_s1;
	logic                    rd_vld_s1;
	logic [LW-1:0]           rd_idx_q;
	logic [LW-1:0]           k_q;
	logic                    hit_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [VW-1:0]           clear_idx_q;

	logic [VW-1:0]           in_src_idx;
	logic                    src_ok, dst_ok, in_bad;
	logic                    issue, match, keep_wr;
	logic [VTX_W-1:0]        rd_tgt;
	logic signed [WGT_W-1:0] rd_wgt;
	logic                    len_we;
	logic [VW-1:0]           len_waddr;
	logic [LW-1:0]           len_wdata;
	logic                    edge_we;
	logic [AW-1:0]           edge_waddr;
	logic [EW-1:0]           edge_wdata;
	logic [AW-1:0]           rd_addr;
	logic signed [CMP_W-1:0] acc_ext, sat;
	logic                    clear_done;

	// Range check on the incoming word
	assign in_src_idx = VW'(in_src);
	assign src_ok = (in_src <= vertex_count) && (32'(in_src) < 32'(MAX_VERTICES));
	assign dst_ok = (in_dst <= vertex_count) && (32'(in_dst) < 32'(MAX_VERTICES));
	assign in_bad = (in_req <= REQ_ISO)
		&& (!src_ok || ((in_req <= REQ_REMOVE) && !dst_ok));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q       <= in_req;
			dst_q       <= in_dst;
			weight_q    <= in_weight;
			src_idx_q   <= in_src_idx;
			base_q      <= AW'(in_src_idx * MAX_DEGREE);
			bad_range_q <= in_bad;
		end
	end

	// Slot read and compaction
	assign rd_tgt  = edge_rd_s1[EW-1 -: VTX_W];
	assign rd_wgt  = edge_rd_s1[WGT_W-1:0];
	assign issue   = cmd.scan && (rd_idx_q < len_rd_s1);
	assign rd_addr = base_q + AW'(rd_idx_q);
	assign match   = rd_vld_s1 && (rd_tgt == dst_q);
	assign keep_wr = rd_vld_s1 && !match && (req_q == REQ_REMOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_idx_q    <= '0;
			k_q         <= '0;
			hit_q       <= 1'b0;
			acc_q       <= '0;
			clear_idx_q <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.start) begin
				rd_idx_q <= '0;
				k_q      <= '0;
				hit_q    <= 1'b0;
				acc_q    <= '0;
			end else begin
				if (issue) rd_idx_q <= rd_idx_q + 1'b1;
				if (keep_wr) k_q <= k_q + 1'b1;
				if (match) hit_q <= 1'b1;
				if (rd_vld_s1) acc_q <= acc_q + ACC_W'(rd_wgt);
			end
			if (cmd.clear && !clear_done) clear_idx_q <= clear_idx_q + 1'b1;
		end
	end

	// Length memory port
	assign clear_done = (clear_idx_q == VW'(MAX_VERTICES - 1));

	always_comb begin
		len_we    = 1'b0;
		len_waddr = src_idx_q;
		len_wdata = k_q;
		priority if (cmd.clear) begin
			len_we    = 1'b1;
			len_waddr = clear_idx_q;
			len_wdata = '0;
		end else if (cmd.ins_wr) begin
			len_we    = 1'b1;
			len_wdata = len_rd_s1 + 1'b1;
		end else if (cmd.len_wr_k) begin
			len_we    = 1'b1;
		end else begin
			len_we    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) len_mem[len_waddr] <= len_wdata;
		if (cmd.start) len_rd_s1 <= len_mem[in_src_idx];
	end

	// Edge memory port
	always_comb begin
		edge_we    = cmd.ins_wr || keep_wr;
		edge_waddr = base_q + AW'(k_q);
		edge_wdata = edge_rd_s1;
		if (cmd.ins_wr) begin
			edge_waddr = base_q + AW'(len_rd_s1);
			edge_wdata = {dst_q, weight_q};
		end
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
		if (issue) edge_rd_s1 <= edge_mem[rd_addr];
	end

	// Status to controller
	assign sts.clear_done = clear_done;
	assign sts.bad_range  = bad_range_q;
	assign sts.len_full   = (len_rd_s1 >= LW'(MAX_DEGREE));
	assign sts.scan_done  = cmd.scan && (rd_idx_q == len_rd_s1) && !rd_vld_s1;
	assign sts.req        = req_q;

	// Saturate the sum
	assign acc_ext = CMP_W'(acc_q);
	assign sat     = (acc_ext > SAT_HI) ? SAT_HI : ((acc_ext < SAT_LO) ? SAT_LO : acc_ext);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			out_status <= STS_OK;
			out_found  <= 1'b0;
			out_sum    <= '0;
			priority if (bad_range_q) begin
				out_status <= STS_RANGE;
			end else if (req_q == REQ_INSERT) begin
				if (sts.len_full) out_status <= STS_FULL;
			end else if (req_q == REQ_ADJ || req_q == REQ_REMOVE) begin
				out_found <= hit_q;
			end else if (req_q == REQ_SUM) begin
				out_sum <= SUM_W'(sat);
			end else if (req_q == REQ_ISO) begin
				out_found <= (len_rd_s1 == '0);
			end else begin
				out_status <= STS_OK;
			end
		end
	end

	// Read data only follows a slot read issued in the scan
	a_rd_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(cmd.scan))
		else $error("slot data valid without a scan read");

	// An append never lands past the end of a full list
	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> (32'(len_rd_s1) < 32'(MAX_DEGREE)))
		else $error("append into a full list");

	// Compaction write pointer trails the read pointer
	a_k_behind: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (k_q < rd_idx_q))
		else $error("compaction write overtook slot read");

endmodule

`default_nettype wire

// ----- rtl/core/weighted_adjacency_list_store_unit.sv -----
// Top level of the weighted adjacency list store: config register, controller, datapath.
//
//  channel  dir  handshake          word
//  req      in   valid/ready        req_type, src_vertex, dst_vertex, weight
//  rsp      out  valid/ready        status, found, weight_sum
//  apb      in   psel/penable       vertex_count at byte address 0
//
// Insert, isolation test and out-of-range requests go from accept through ST_LEN and
// ST_RSP to the result register. Adjacency test, removal and sum also pass ST_SCAN,
// which walks the L slots of the list (L at most MAX_DEGREE, none for an empty list);
// the edge memory read port gives one slot per cycle. After reset a clearing pass zeroes
// all MAX_VERTICES list lengths; no request word is taken meanwhile.
// A finished result waits in the output register; the next request is taken
// while it is held, and it is loaded only once the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module weighted_adjacency_list_store_unit
	import wals_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	wals_req_if.sink         req,
	wals_rsp_if.source       rsp
);

	logic [VTX_W-1:0] vertex_count_q;
	logic             cfg_wr;
	dp_cmd_t          cmd;
	dp_sts_t          sts;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr) begin
			vertex_count_q <= pwdata[VTX_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count_q) : 32'd0;

	wals_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wals_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_DEGREE   (MAX_DEGREE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.vertex_count (vertex_count_q),
		.in_req       (req.req_type),
		.in_src       (req.src_vertex),
		.in_dst       (req.dst_vertex),
		.in_weight    (req.weight),
		.out_status   (rsp.status),
		.out_found    (rsp.found),
		.out_sum      (rsp.weight_sum)
	);

endmodule

`default_nettype wire
